// ===== src/ses_pkg.sv =====
// Shared types and constants for the sector error statistics block.
// Used by the top level, the rating logic and the port checker. No dependencies.
package ses_pkg;

	// input word fields, lowest bit first
	localparam int ADDR_FIELD_W = 19;
	localparam int ERR_W        = 12;
	localparam int SENSE_W      = 4;
	localparam int S_TDATA_W    = 40;

	localparam int S_ADDR_OFF   = 0;
	localparam int S_OK_OFF     = 19;
	localparam int S_ERR_OFF    = 20;
	localparam int S_SENSE_OFF  = 32;

	// counter widths
	localparam int CNT_W    = 20;
	localparam int SUM_W    = 32;
	localparam int BSUM_W   = 18;
	localparam int SEC_W    = 13;
	localparam int RATING_W = 3;

	// summary word fields, lowest bit first
	localparam int M_TDATA_W      = 240;
	localparam int M_SEEN_OFF     = 0;
	localparam int M_ERRTOT_OFF   = 20;
	localparam int M_ERRSEC_OFF   = 52;
	localparam int M_FIXSEC_OFF   = 72;
	localparam int M_FIXERR_OFF   = 92;
	localparam int M_FAIL_OFF     = 124;
	localparam int M_WORST_OFF    = 144;
	localparam int M_WADDR_OFF    = 156;
	localparam int M_RUN_OFF      = 175;
	localparam int M_PEAK_OFF     = 195;
	localparam int M_PADDR_OFF    = 213;
	localparam int M_RATING_OFF   = 232;
	localparam int M_USED_W       = 235;

	localparam logic [SENSE_W-1:0] SENSE_RECOVERED = 4'h1;

	localparam logic [RATING_W-1:0] RATE_EXCELLENT  = 3'd0;
	localparam logic [RATING_W-1:0] RATE_GOOD       = 3'd1;
	localparam logic [RATING_W-1:0] RATE_ACCEPTABLE = 3'd2;
	localparam logic [RATING_W-1:0] RATE_FAIR       = 3'd3;
	localparam logic [RATING_W-1:0] RATE_POOR       = 3'd4;
	localparam logic [RATING_W-1:0] RATE_BAD        = 3'd5;

	localparam int GOOD_RUN_LIM   = 3;
	localparam int GOOD_WORST_LIM = 50;
	localparam int ACC_RUN_LIM    = 10;
	localparam int ACC_WORST_LIM  = 100;
	localparam int ACC_FACTOR     = 10;
	localparam int FAIR_FACTOR    = 50;

	typedef struct packed {
		logic [CNT_W-1:0]        sectors_seen;
		logic [SUM_W-1:0]        error_total;
		logic [CNT_W-1:0]        error_sectors;
		logic [CNT_W-1:0]        fixed_sectors;
		logic [SUM_W-1:0]        fixed_errors;
		logic [CNT_W-1:0]        failed_reads;
		logic [ERR_W-1:0]        worst_count;
		logic [ADDR_FIELD_W-1:0] worst_address;
		logic [CNT_W-1:0]        longest_run;
		logic [BSUM_W-1:0]       peak_second;
		logic [ADDR_FIELD_W-1:0] peak_second_address;
		logic [SEC_W-1:0]        seconds;
	} summary_t;

endpackage

// ===== src/ses_rating.sv =====
// Quality rating of a finished scan from its summary figures.
// Depends on ses_pkg.
module ses_rating (
	input  ses_pkg::summary_t              summary,
	output logic [ses_pkg::RATING_W-1:0]   rating
);
	import ses_pkg::*;

	logic [SUM_W-1:0] secs;
	logic [SUM_W-1:0] secs_acc;
	logic [SUM_W-1:0] secs_fair;

	// per-second averages become compares against scaled second counts
	assign secs      = SUM_W'(summary.seconds);
	assign secs_acc  = SUM_W'(summary.seconds) * SUM_W'(ACC_FACTOR);
	assign secs_fair = SUM_W'(summary.seconds) * SUM_W'(FAIR_FACTOR);

	always_comb begin
		if (summary.failed_reads != '0) begin
			rating = RATE_BAD;
		end else if (summary.error_sectors == '0) begin
			rating = RATE_EXCELLENT;
		end else if (summary.error_total < secs
				&& summary.longest_run < CNT_W'(GOOD_RUN_LIM)
				&& summary.worst_count < ERR_W'(GOOD_WORST_LIM)) begin
			rating = RATE_GOOD;
		end else if (summary.error_total < secs_acc
				&& summary.longest_run < CNT_W'(ACC_RUN_LIM)
				&& summary.worst_count < ERR_W'(ACC_WORST_LIM)) begin
			rating = RATE_ACCEPTABLE;
		end else if (summary.error_total < secs_fair) begin
			rating = RATE_FAIR;
		end else begin
			rating = RATE_POOR;
		end
	end

endmodule

// ===== src/sector_error_statistics_top.sv =====
// Sector error statistics: top level with the statistics state and the summary pipeline.
// Depends on ses_pkg and ses_rating.
//
// Usage: one word per scanned sector on the s_ channel; s_tlast marks the final
// sector of the scan and s_tuser marks the first sector of a track. One summary
// word leaves on the m_ channel for every final sector; other sectors give none.
// Throughput: one sector word per cycle unless a final sector waits (see Stalls);
// every statistic is a single saturating add or compare between the input
// register and the state registers.
// Path: the accepting edge fills the input register with the final sector, then
// the snapshot register, then the output register that drives m_tvalid; the rating
// is worked out on the way from snapshot to output.
// Stalls: while m_tready is low, ordinary sector words keep flowing. A final
// sector waits in the input register only when both the snapshot and the output
// register hold summaries not yet taken, and s_tready then drops.
// Reset: every statistic, the second position and all valid flags clear; no
// clearing pass is needed. All statistics also clear right after a summary.
module sector_error_statistics_top #(
	parameter int ADDR_WIDTH         = 19,
	parameter int SECTORS_PER_BUCKET = 75
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sector_address[18:0], read_ok[19], error_count[31:20], sense_code[35:32]
	input  logic [ses_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	// track_begin[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// sectors_seen[19:0], error_total[51:20], error_sectors[71:52],
	// fixed_sectors[91:72], fixed_errors[123:92], failed_reads[143:124],
	// worst_count[155:144], worst_address[174:156], longest_run[194:175],
	// peak_second[212:195], peak_second_address[231:213], rating[234:232]
	output logic [ses_pkg::M_TDATA_W-1:0] m_tdata
);
	import ses_pkg::*;

	localparam int POS_W = (SECTORS_PER_BUCKET > 1) ? $clog2(SECTORS_PER_BUCKET) : 1;
	localparam int EXT_W = ADDR_WIDTH + ADDR_FIELD_W;

	// input register
	logic                    valid_s1;
	logic [ADDR_FIELD_W-1:0] addr_s1;
	logic                    ok_s1;
	logic [ERR_W-1:0]        errs_s1;
	logic [SENSE_W-1:0]      sense_s1;
	logic                    tbeg_s1;
	logic                    last_s1;

	// statistics
	logic [CNT_W-1:0]      seen_q, err_sec_q, rec_sec_q, fail_q, run_now_q, run_best_q;
	logic [SUM_W-1:0]      err_sum_q, rec_sum_q;
	logic [SEC_W-1:0]      secs_q;
	logic [ERR_W-1:0]      max_errs_q;
	logic [ADDR_WIDTH-1:0] max_addr_q, bkt_addr_q, bkt_best_addr_q;
	logic [POS_W-1:0]      bkt_pos_q;
	logic [BSUM_W-1:0]     bkt_sum_q, bkt_best_q;

	logic [CNT_W-1:0]      n_seen, n_err_sec, n_rec_sec, n_fail, n_run_now, n_run_best;
	logic [SUM_W-1:0]      n_err_sum, n_rec_sum;
	logic [SEC_W-1:0]      n_secs;
	logic [ERR_W-1:0]      n_max_errs;
	logic [ADDR_WIDTH-1:0] n_max_addr, n_bkt_addr, n_bkt_best_addr;
	logic [POS_W-1:0]      n_bkt_pos;
	logic [BSUM_W-1:0]     n_bkt_sum, n_bkt_best;

	logic [EXT_W-1:0]      addr_in_ext, waddr_ext, paddr_ext;
	logic [ADDR_WIDTH-1:0] addr;
	logic                  is_fail, is_unrec, is_rec, first_in_bkt;
	logic [CNT_W-1:0]      run_base, run_inc;
	logic [BSUM_W-1:0]     bkt_base, bkt_add;
	logic [BSUM_W:0]       bkt_wide;
	logic [SUM_W:0]        err_wide, rec_wide;

	// summary path
	logic                  snap_valid_q;
	summary_t              snap_q;
	summary_t              n_snap;
	logic [RATING_W-1:0]   rating;
	logic [M_TDATA_W-1:0]  out_word;
	logic                  s1_go, snap_go, snap_free;

	assign snap_go   = snap_valid_q && (!m_tvalid || m_tready);
	assign snap_free = !snap_valid_q || snap_go;
	assign s1_go     = valid_s1 && (!last_s1 || snap_free);
	assign s_tready  = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			addr_s1  <= s_tdata[S_ADDR_OFF +: ADDR_FIELD_W];
			ok_s1    <= s_tdata[S_OK_OFF];
			errs_s1  <= s_tdata[S_ERR_OFF +: ERR_W];
			sense_s1 <= s_tdata[S_SENSE_OFF +: SENSE_W];
			tbeg_s1  <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// next statistics for the word in the input register
	always_comb begin
		addr_in_ext  = {{ADDR_WIDTH{1'b0}}, addr_s1};
		addr         = addr_in_ext[ADDR_WIDTH-1:0];
		is_fail      = !ok_s1;
		is_unrec     = ok_s1 && (errs_s1 != '0) && (sense_s1 != SENSE_RECOVERED);
		is_rec       = ok_s1 && (errs_s1 != '0) && (sense_s1 == SENSE_RECOVERED);
		first_in_bkt = (bkt_pos_q == '0);

		n_seen    = (&seen_q) ? seen_q : seen_q + 1'b1;
		n_bkt_pos = (bkt_pos_q == POS_W'(SECTORS_PER_BUCKET - 1)) ? '0 : bkt_pos_q + 1'b1;

		n_secs     = (first_in_bkt && !(&secs_q)) ? secs_q + 1'b1 : secs_q;
		n_bkt_addr = first_in_bkt ? addr : bkt_addr_q;
		bkt_base   = first_in_bkt ? '0 : bkt_sum_q;

		if (is_fail) begin
			bkt_add = BSUM_W'(1);
		end else if (is_unrec) begin
			bkt_add = BSUM_W'(errs_s1);
		end else begin
			bkt_add = '0;
		end
		bkt_wide  = {1'b0, bkt_base} + {1'b0, bkt_add};
		n_bkt_sum = bkt_wide[BSUM_W] ? '1 : bkt_wide[BSUM_W-1:0];

		if (n_bkt_sum > bkt_best_q) begin
			n_bkt_best      = n_bkt_sum;
			n_bkt_best_addr = n_bkt_addr;
		end else begin
			n_bkt_best      = bkt_best_q;
			n_bkt_best_addr = bkt_best_addr_q;
		end

		// bad run: failed or unrecovered sectors in a row, restarted per track
		run_base   = tbeg_s1 ? '0 : run_now_q;
		run_inc    = (&run_base) ? run_base : run_base + 1'b1;
		n_run_now  = (is_fail || is_unrec) ? run_inc : '0;
		n_run_best = (n_run_now > run_best_q) ? n_run_now : run_best_q;

		n_fail = (is_fail && !(&fail_q)) ? fail_q + 1'b1 : fail_q;

		err_wide  = {1'b0, err_sum_q} + (SUM_W + 1)'(errs_s1);
		n_err_sum = !is_unrec ? err_sum_q : (err_wide[SUM_W] ? '1 : err_wide[SUM_W-1:0]);
		n_err_sec = (is_unrec && !(&err_sec_q)) ? err_sec_q + 1'b1 : err_sec_q;

		if (is_unrec && errs_s1 > max_errs_q) begin
			n_max_errs = errs_s1;
			n_max_addr = addr;
		end else begin
			n_max_errs = max_errs_q;
			n_max_addr = max_addr_q;
		end

		rec_wide  = {1'b0, rec_sum_q} + (SUM_W + 1)'(errs_s1);
		n_rec_sum = !is_rec ? rec_sum_q : (rec_wide[SUM_W] ? '1 : rec_wide[SUM_W-1:0]);
		n_rec_sec = (is_rec && !(&rec_sec_q)) ? rec_sec_q + 1'b1 : rec_sec_q;

		waddr_ext = {{ADDR_FIELD_W{1'b0}}, n_max_addr};
		paddr_ext = {{ADDR_FIELD_W{1'b0}}, n_bkt_best_addr};

		n_snap.sectors_seen        = n_seen;
		n_snap.error_total         = n_err_sum;
		n_snap.error_sectors       = n_err_sec;
		n_snap.fixed_sectors       = n_rec_sec;
		n_snap.fixed_errors        = n_rec_sum;
		n_snap.failed_reads        = n_fail;
		n_snap.worst_count         = n_max_errs;
		n_snap.worst_address       = waddr_ext[ADDR_FIELD_W-1:0];
		n_snap.longest_run         = n_run_best;
		n_snap.peak_second         = n_bkt_best;
		n_snap.peak_second_address = paddr_ext[ADDR_FIELD_W-1:0];
		n_snap.seconds             = n_secs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q          <= '0;
			secs_q          <= '0;
			err_sum_q       <= '0;
			err_sec_q       <= '0;
			rec_sec_q       <= '0;
			rec_sum_q       <= '0;
			fail_q          <= '0;
			max_errs_q      <= '0;
			max_addr_q      <= '0;
			run_now_q       <= '0;
			run_best_q      <= '0;
			bkt_pos_q       <= '0;
			bkt_sum_q       <= '0;
			bkt_addr_q      <= '0;
			bkt_best_q      <= '0;
			bkt_best_addr_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				// summary taken: start the next scan from nothing
				seen_q          <= '0;
				secs_q          <= '0;
				err_sum_q       <= '0;
				err_sec_q       <= '0;
				rec_sec_q       <= '0;
				rec_sum_q       <= '0;
				fail_q          <= '0;
				max_errs_q      <= '0;
				max_addr_q      <= '0;
				run_now_q       <= '0;
				run_best_q      <= '0;
				bkt_pos_q       <= '0;
				bkt_sum_q       <= '0;
				bkt_addr_q      <= '0;
				bkt_best_q      <= '0;
				bkt_best_addr_q <= '0;
			end else begin
				seen_q          <= n_seen;
				secs_q          <= n_secs;
				err_sum_q       <= n_err_sum;
				err_sec_q       <= n_err_sec;
				rec_sec_q       <= n_rec_sec;
				rec_sum_q       <= n_rec_sum;
				fail_q          <= n_fail;
				max_errs_q      <= n_max_errs;
				max_addr_q      <= n_max_addr;
				run_now_q       <= n_run_now;
				run_best_q      <= n_run_best;
				bkt_pos_q       <= n_bkt_pos;
				bkt_sum_q       <= n_bkt_sum;
				bkt_addr_q      <= n_bkt_addr;
				bkt_best_q      <= n_bkt_best;
				bkt_best_addr_q <= n_bkt_best_addr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			snap_valid_q <= 1'b1;
		end else if (snap_go) begin
			snap_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			snap_q <= n_snap;
		end
	end

	ses_rating u_rating (
		.summary (snap_q),
		.rating  (rating)
	);

	always_comb begin
		out_word                                      = '0;
		out_word[M_SEEN_OFF   +: CNT_W]               = snap_q.sectors_seen;
		out_word[M_ERRTOT_OFF +: SUM_W]               = snap_q.error_total;
		out_word[M_ERRSEC_OFF +: CNT_W]               = snap_q.error_sectors;
		out_word[M_FIXSEC_OFF +: CNT_W]               = snap_q.fixed_sectors;
		out_word[M_FIXERR_OFF +: SUM_W]               = snap_q.fixed_errors;
		out_word[M_FAIL_OFF   +: CNT_W]               = snap_q.failed_reads;
		out_word[M_WORST_OFF  +: ERR_W]               = snap_q.worst_count;
		out_word[M_WADDR_OFF  +: ADDR_FIELD_W]        = snap_q.worst_address;
		out_word[M_RUN_OFF    +: CNT_W]               = snap_q.longest_run;
		out_word[M_PEAK_OFF   +: BSUM_W]              = snap_q.peak_second;
		out_word[M_PADDR_OFF  +: ADDR_FIELD_W]        = snap_q.peak_second_address;
		out_word[M_RATING_OFF +: RATING_W]            = rating;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (snap_go) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_go) begin
			m_tdata <= out_word;
		end
	end

endmodule

// ===== src/ses_checker.sv =====
// Port-level checks on summary words of the sector error statistics block,
// bound to sector_error_statistics_top. Depends on ses_pkg.
module ses_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ses_pkg::M_TDATA_W-1:0] m_tdata
);
	import ses_pkg::*;

	logic [CNT_W-1:0]    seen, err_sec, fail, run;
	logic [SUM_W-1:0]    err_tot;
	logic [ERR_W-1:0]    worst;
	logic [RATING_W-1:0] rating;

	assign seen    = m_tdata[M_SEEN_OFF   +: CNT_W];
	assign err_tot = m_tdata[M_ERRTOT_OFF +: SUM_W];
	assign err_sec = m_tdata[M_ERRSEC_OFF +: CNT_W];
	assign fail    = m_tdata[M_FAIL_OFF   +: CNT_W];
	assign worst   = m_tdata[M_WORST_OFF  +: ERR_W];
	assign run     = m_tdata[M_RUN_OFF    +: CNT_W];
	assign rating  = m_tdata[M_RATING_OFF +: RATING_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("summary word changed while stalled");

	// a bad rating exactly when some read failed
	a_bad_rating: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((fail != '0) == (rating == RATE_BAD)))
		else $error("rating disagrees with failed read count");

	a_no_errors: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_sec == '0 |-> worst == '0 && err_tot == '0)
		else $error("error figures without error sectors");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen != '0 && fail <= seen && err_sec <= seen && run <= seen)
		else $error("sector counts exceed sectors seen");

endmodule

bind sector_error_statistics_top ses_checker u_ses_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== sim/sector_error_statistics_checker.sv =====
// Scoreboard for the sector error statistics block: watches the sector and summary
// ports, keeps its own per-scan statistics and compares every summary word field by field.
// Depends on ses_pkg for the word layouts and the rating codes.
`timescale 1ns / 100ps
module sector_error_statistics_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// sector_address[18:0], read_ok[19], error_count[31:20], sense_code[35:32]
	input  logic [ses_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	// track_begin[0]
	input  logic                          s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// summary fields as laid out in ses_pkg, sectors_seen lowest
	input  logic [ses_pkg::M_TDATA_W-1:0] m_tdata,
	output int                            mismatches,
	output int                            summaries_due,
	output int                            sectors_taken,
	output int                            summaries_taken,
	output logic [5:0]                    ratings_seen
);
	import ses_pkg::*;

	localparam int SUMMARY_FIELDS = 12;
	localparam longint unsigned BUCKET_LEN = 75;

	localparam longint unsigned CNT_CAP  = (64'd1 << CNT_W) - 1;
	localparam longint unsigned SUM_CAP  = (64'd1 << SUM_W) - 1;
	localparam longint unsigned BSUM_CAP = (64'd1 << BSUM_W) - 1;
	localparam longint unsigned SEC_CAP  = (64'd1 << SEC_W) - 1;

	// grading thresholds
	localparam longint unsigned RUN_FOR_GOOD   = 3;
	localparam longint unsigned WORST_FOR_GOOD = 50;
	localparam longint unsigned RUN_FOR_ACC    = 10;
	localparam longint unsigned WORST_FOR_ACC  = 100;
	localparam longint unsigned ACC_PER_SEC    = 10;
	localparam longint unsigned FAIR_PER_SEC   = 50;

	longint unsigned n_seen, n_secs, unrec_sum, n_unrec, n_rec, rec_sum, n_fail;
	longint unsigned worst_errs, worst_addr, run_len, run_max;
	longint unsigned sec_pos, sec_sum, sec_addr, sec_peak, sec_peak_addr;

	logic [M_TDATA_W-1:0] summary_q[$];
	int bad_fields, n_sectors, n_summaries;
	logic [5:0] rated;

	function automatic longint unsigned sat_add(longint unsigned v, longint unsigned a,
		longint unsigned cap);
		return (v + a > cap) ? cap : v + a;
	endfunction

	function automatic logic [RATING_W-1:0] grade();
		if (n_fail > 0) return RATE_BAD;
		if (n_unrec == 0) return RATE_EXCELLENT;
		if (unrec_sum < n_secs && run_max < RUN_FOR_GOOD && worst_errs < WORST_FOR_GOOD)
			return RATE_GOOD;
		if (unrec_sum < ACC_PER_SEC * n_secs && run_max < RUN_FOR_ACC
			&& worst_errs < WORST_FOR_ACC)
			return RATE_ACCEPTABLE;
		if (unrec_sum < FAIR_PER_SEC * n_secs) return RATE_FAIR;
		return RATE_POOR;
	endfunction

	function automatic void field_spec(input int idx, output int lsb, output int w,
		output string nm);
		case (idx)
		0: begin lsb = M_SEEN_OFF; w = CNT_W; nm = "sectors_seen"; end
		1: begin lsb = M_ERRTOT_OFF; w = SUM_W; nm = "error_total"; end
		2: begin lsb = M_ERRSEC_OFF; w = CNT_W; nm = "error_sectors"; end
		3: begin lsb = M_FIXSEC_OFF; w = CNT_W; nm = "fixed_sectors"; end
		4: begin lsb = M_FIXERR_OFF; w = SUM_W; nm = "fixed_errors"; end
		5: begin lsb = M_FAIL_OFF; w = CNT_W; nm = "failed_reads"; end
		6: begin lsb = M_WORST_OFF; w = ERR_W; nm = "worst_count"; end
		7: begin lsb = M_WADDR_OFF; w = ADDR_FIELD_W; nm = "worst_address"; end
		8: begin lsb = M_RUN_OFF; w = CNT_W; nm = "longest_run"; end
		9: begin lsb = M_PEAK_OFF; w = BSUM_W; nm = "peak_second"; end
		10: begin lsb = M_PADDR_OFF; w = ADDR_FIELD_W; nm = "peak_second_address"; end
		default: begin lsb = M_RATING_OFF; w = RATING_W; nm = "rating"; end
		endcase
	endfunction

	task automatic clear_stats();
		n_seen = 0; n_secs = 0; unrec_sum = 0; n_unrec = 0; n_rec = 0; rec_sum = 0;
		n_fail = 0; worst_errs = 0; worst_addr = 0; run_len = 0; run_max = 0;
		sec_pos = 0; sec_sum = 0; sec_addr = 0; sec_peak = 0; sec_peak_addr = 0;
	endtask

	task automatic extend_bad_run();
		run_len = sat_add(run_len, 1, CNT_CAP);
		if (run_len > run_max) run_max = run_len;
	endtask

	task automatic take_sector(input logic [S_TDATA_W-1:0] w, input logic tbeg,
		input logic last);
		longint unsigned addr, errs;
		logic ok;
		logic [SENSE_W-1:0] sense;
		logic [RATING_W-1:0] g;
		logic [M_TDATA_W-1:0] s;
		addr  = w[S_ADDR_OFF +: ADDR_FIELD_W];
		ok    = w[S_OK_OFF];
		errs  = w[S_ERR_OFF +: ERR_W];
		sense = w[S_SENSE_OFF +: SENSE_W];

		if (tbeg) run_len = 0;
		// first sector of a second opens a fresh bucket
		if (sec_pos == 0) begin
			sec_addr = addr;
			sec_sum  = 0;
			n_secs   = sat_add(n_secs, 1, SEC_CAP);
		end

		if (!ok) begin
			n_fail  = sat_add(n_fail, 1, CNT_CAP);
			sec_sum = sat_add(sec_sum, 1, BSUM_CAP);
			extend_bad_run();
		end else if (errs > 0 && sense != SENSE_RECOVERED) begin
			unrec_sum = sat_add(unrec_sum, errs, SUM_CAP);
			n_unrec   = sat_add(n_unrec, 1, CNT_CAP);
			sec_sum   = sat_add(sec_sum, errs, BSUM_CAP);
			if (errs > worst_errs) begin
				worst_errs = errs;
				worst_addr = addr;
			end
			extend_bad_run();
		end else if (errs > 0) begin
			run_len = 0;
			rec_sum = sat_add(rec_sum, errs, SUM_CAP);
			n_rec   = sat_add(n_rec, 1, CNT_CAP);
		end else begin
			run_len = 0;
		end

		if (sec_sum > sec_peak) begin
			sec_peak      = sec_sum;
			sec_peak_addr = sec_addr;
		end
		sec_pos = (sec_pos + 1 >= BUCKET_LEN) ? 0 : sec_pos + 1;
		n_seen  = sat_add(n_seen, 1, CNT_CAP);

		if (last) begin
			g = grade();
			s = '0;
			s[M_SEEN_OFF +: CNT_W]           = n_seen[CNT_W-1:0];
			s[M_ERRTOT_OFF +: SUM_W]         = unrec_sum[SUM_W-1:0];
			s[M_ERRSEC_OFF +: CNT_W]         = n_unrec[CNT_W-1:0];
			s[M_FIXSEC_OFF +: CNT_W]         = n_rec[CNT_W-1:0];
			s[M_FIXERR_OFF +: SUM_W]         = rec_sum[SUM_W-1:0];
			s[M_FAIL_OFF +: CNT_W]           = n_fail[CNT_W-1:0];
			s[M_WORST_OFF +: ERR_W]          = worst_errs[ERR_W-1:0];
			s[M_WADDR_OFF +: ADDR_FIELD_W]   = worst_addr[ADDR_FIELD_W-1:0];
			s[M_RUN_OFF +: CNT_W]            = run_max[CNT_W-1:0];
			s[M_PEAK_OFF +: BSUM_W]          = sec_peak[BSUM_W-1:0];
			s[M_PADDR_OFF +: ADDR_FIELD_W]   = sec_peak_addr[ADDR_FIELD_W-1:0];
			s[M_RATING_OFF +: RATING_W]      = g;
			rated[g] = 1'b1;
			summary_q = {summary_q, s};
			clear_stats();
		end
	endtask

	task automatic check_summary(input logic [M_TDATA_W-1:0] want,
		input logic [M_TDATA_W-1:0] got);
		int lsb, w;
		string nm;
		longint unsigned mask, e, a;
		for (int i = 0; i < SUMMARY_FIELDS; i++) begin
			field_spec(i, lsb, w, nm);
			mask = (64'd1 << w) - 1;
			e = 64'(want >> lsb) & mask;
			a = 64'(got >> lsb) & mask;
			if (e != a) begin
				bad_fields++;
				$display("%0t: summary %0d field %s expected %0d, got %0d",
					$time, n_summaries, nm, e, a);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stats();
			summary_q.delete();
			bad_fields      = 0;
			n_sectors       = 0;
			n_summaries     = 0;
			rated           = '0;
			mismatches      <= 0;
			summaries_due   <= 0;
			sectors_taken   <= 0;
			summaries_taken <= 0;
			ratings_seen    <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (summary_q.size() == 0) begin
					bad_fields++;
					$display("%0t: summary word expected none, got %h", $time, m_tdata);
				end else begin
					check_summary(summary_q.pop_front(), m_tdata);
				end
				n_summaries++;
			end
			if (s_tvalid && s_tready) begin
				n_sectors++;
				take_sector(s_tdata, s_tuser, s_tlast);
			end
			mismatches      <= bad_fields;
			summaries_due   <= summary_q.size();
			sectors_taken   <= n_sectors;
			summaries_taken <= n_summaries;
			ratings_seen    <= rated;
		end
	end

endmodule

// ===== sim/sector_error_statistics_top_test.sv =====
// Testbench top for the sector error statistics block: clock, reset, sector stimulus
// in directed and random scans, summary port back-pressure, watchdog and verdict.
// Depends on ses_pkg, sector_error_statistics_top and sector_error_statistics_checker.
`timescale 1ns / 100ps
module sector_error_statistics_top_test;
	import ses_pkg::*;

	typedef enum int {
		SCAN_CLEAN, SCAN_LIGHT, SCAN_MODERATE, SCAN_DENSE, SCAN_FAILING, SCAN_FLOOD
	} scan_kind_t;

	typedef enum int {
		SECTOR_CLEAN, SECTOR_RECOVERED, SECTOR_UNRECOVERED, SECTOR_FAILED
	} sector_class_t;

	localparam int SECTOR_TARGET = 1350;
	localparam int SCAN_TARGET   = 24;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int MAX_ERRS      = 4095;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tready = 1'b0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [M_TDATA_W-1:0]   m_tdata;

	int gap_pct = 0;
	int stall_pct = 0;
	int quiet = 0;
	int sent = 0;
	int scans = 0;
	logic [ADDR_FIELD_W-1:0] next_addr = '0;

	int mismatches, summaries_due, sectors_taken, summaries_taken;
	logic [5:0] ratings_seen;

	sector_error_statistics_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sector_error_statistics_checker stats_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.summaries_due   (summaries_due),
		.sectors_taken   (sectors_taken),
		.summaries_taken (summaries_taken),
		.ratings_seen    (ratings_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// ends the run if neither port moves a word for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic put_sector(input logic [ADDR_FIELD_W-1:0] addr, input logic ok,
		input logic [ERR_W-1:0] errs, input logic [SENSE_W-1:0] sense,
		input logic tbeg, input logic last);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, sense, errs, ok, addr};
		s_tlast  <= last;
		s_tuser  <= tbeg;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (last) scans++;
	endtask

	task automatic run_scan(input scan_kind_t kind, input int len);
		logic ok, tbeg;
		logic [ERR_W-1:0] errs;
		logic [SENSE_W-1:0] sense;
		sector_class_t cls;
		int r, lo, hi, cap;
		cap = $urandom_range(1) ? 60 : MAX_ERRS;
		for (int i = 0; i < len; i++) begin
			r    = $urandom_range(999);
			lo   = 1;
			hi   = MAX_ERRS;
			tbeg = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
			case (kind)
			SCAN_CLEAN:
				cls = (r < 100) ? SECTOR_RECOVERED : SECTOR_CLEAN;
			SCAN_LIGHT: begin
				cls = (r < 8) ? SECTOR_UNRECOVERED
					: (r < 60) ? SECTOR_RECOVERED : SECTOR_CLEAN;
				hi = 1;
			end
			SCAN_MODERATE: begin
				cls = (r < 30) ? SECTOR_UNRECOVERED
					: (r < 80) ? SECTOR_RECOVERED : SECTOR_CLEAN;
				hi = (r < 5) ? 99 : 6;
			end
			SCAN_DENSE: begin
				cls = (r < 20) ? SECTOR_FAILED : (r < 500) ? SECTOR_UNRECOVERED
					: (r < 600) ? SECTOR_RECOVERED : SECTOR_CLEAN;
				hi = cap;
			end
			SCAN_FAILING: begin
				cls = (r < 100) ? SECTOR_FAILED : (r < 300) ? SECTOR_UNRECOVERED
					: (r < 350) ? SECTOR_RECOVERED : SECTOR_CLEAN;
				hi = 2352;
			end
			default: begin
				// heavy enough to pin the per-second sum at its ceiling
				cls = SECTOR_UNRECOVERED;
				lo  = 3500;
			end
			endcase

			ok    = 1'b1;
			errs  = '0;
			sense = SENSE_W'($urandom_range(15));
			case (cls)
			SECTOR_FAILED: begin
				ok   = 1'b0;
				errs = ERR_W'($urandom_range(MAX_ERRS));
			end
			SECTOR_UNRECOVERED: begin
				errs = ERR_W'($urandom_range(hi, lo));
				if (sense == SENSE_RECOVERED) sense = ~sense;
			end
			SECTOR_RECOVERED: begin
				errs  = ERR_W'($urandom_range(MAX_ERRS, 1));
				sense = SENSE_RECOVERED;
			end
			default: ;
			endcase

			put_sector(next_addr, ok, errs, sense, tbeg, i == len - 1);
			if ($urandom_range(39) == 0)
				next_addr = ADDR_FIELD_W'($urandom);
			else
				next_addr = next_addr + 1'b1;
		end
	endtask

	initial begin
		int p, len;
		scan_kind_t kind;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sector scan: sense says recovered but there are no errors
		put_sector('0, 1'b1, '0, SENSE_RECOVERED, 1'b1, 1'b1);
		// top address with the largest count, a failed read, a recovered sector
		put_sector('1, 1'b1, '1, 4'h0, 1'b0, 1'b0);
		put_sector('0, 1'b0, 12'h5A5, SENSE_RECOVERED, 1'b0, 1'b0);
		put_sector(19'd1, 1'b1, 12'd2352, SENSE_RECOVERED, 1'b0, 1'b1);
		// bad run cut by a track start, then by a recovered sector
		for (int i = 0; i < 9; i++)
			put_sector(ADDR_FIELD_W'(1000 + i), 1'b1, ERR_W'(i + 1), SENSE_W'(i + 2),
				i == 5, 1'b0);
		put_sector(19'd1009, 1'b1, 12'd7, SENSE_RECOVERED, 1'b0, 1'b0);
		put_sector(19'd1010, 1'b1, 12'd3, 4'hF, 1'b0, 1'b0);
		put_sector(19'd1011, 1'b1, 12'd0, 4'h3, 1'b0, 1'b1);

		next_addr = ADDR_FIELD_W'($urandom);
		while (sent < SECTOR_TARGET || scans < SCAN_TARGET) begin
			case (sent * 4 / SECTOR_TARGET)
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 83; stall_pct = 0; end
			2: begin gap_pct = 0; stall_pct = 83; end
			default: begin gap_pct = 32; stall_pct = 32; end
			endcase
			p = $urandom_range(99);
			if (p < 20) begin
				kind = SCAN_CLEAN; len = $urandom_range(40, 1);
			end else if (p < 35) begin
				kind = SCAN_LIGHT; len = $urandom_range(160, 76);
			end else if (p < 55) begin
				kind = SCAN_MODERATE; len = $urandom_range(100, 1);
			end else if (p < 75) begin
				kind = SCAN_DENSE; len = $urandom_range(40, 1);
			end else if (p < 92) begin
				kind = SCAN_FAILING; len = $urandom_range(40, 1);
			end else begin
				kind = SCAN_FLOOD; len = $urandom_range(160, 75);
			end
			run_scan(kind, len);
		end

		s_tvalid  <= 1'b0;
		stall_pct = 0;
		@(posedge clk);
		while (summaries_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run fed %0d sectors in %0d scans; %0d summary words compared.",
			sectors_taken, scans, summaries_taken);
		$display("Grades reached, one bit each from excellent upwards: %06b", ratings_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
